FILE: hdl/twla_pkg.sv
// Package for the tiled weight layout address block.
// Holds the request and result types, status and register codes and layout constants.
// Depends on nothing; used by hdl/tiled_weight_layout_address.sv.
package twla_pkg;

    localparam int KSEG_LOG2   = 13;
    localparam int SEGMENT_LEN = 1 << KSEG_LOG2;
    localparam int MAX_DIM     = 65536;

    localparam logic [1:0] MODE_HALF = 2'd0;
    localparam logic [1:0] MODE_INT8 = 2'd1;
    localparam logic [1:0] MODE_INT4 = 2'd2;

    typedef enum logic [2:0] {
        CFG_PACK_MODE = 3'd0,
        CFG_K_TOTAL   = 3'd1,
        CFG_N_TOTAL   = 3'd2,
        CFG_N_FIRST   = 3'd3,
        CFG_N_COUNT   = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_MISALIGNED = 2'd1,
        STATUS_OUTSIDE    = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] k_index;
        logic [15:0] n_index;
        logic [15:0] element_value;
    } request_t;

    typedef struct packed {
        logic [31:0] dest_offset;
        logic [15:0] value_out;
        status_t     status;
    } result_t;

endpackage

FILE: hdl/tiled_weight_layout_address.sv
// Top level of the tiled weight layout address block.
// Maps one matrix element to its offset in the tiled layout; uses hdl/twla_pkg.sv.
//
// Channel   Direction  Handshake                  Payload
// request   in         start high, busy low       twla_pkg::request_t
// result    out        done strobe, one cycle     twla_pkg::result_t
// config    in         cfg_write, no wait         cfg_index, cfg_data
//
// A request may be issued in every cycle; busy is held low.
// Each result is registered through stages s1, s2 and s3 and appears in request order.
// The three stages are: checks and segment split, the two multiplications, the final sum.
// Reset clears the pipeline valid bits and loads the register reset values.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module tiled_weight_layout_address (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  twla_pkg::request_t  request,
    output logic                done,
    output twla_pkg::result_t   result,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [16:0]         cfg_data
);

    logic [1:0]  pack_mode_reg;
    logic [16:0] k_total_reg;
    logic [16:0] n_total_reg;
    logic [15:0] n_first_reg;
    logic [16:0] n_count_reg;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    twla_pkg::status_t  s1_status_reg, s2_status_reg;
    twla_pkg::status_t  s1_status_next;
    logic [15:0]        s1_value_reg, s2_value_reg;
    logic [15:0]        s1_nl_hi_reg, s1_nl_hi_next;
    logic [16:0]        s1_kseg_reg, s1_kseg_next;
    logic [15:0]        s1_kb_reg, s1_kb_next;
    logic [31:0]        s1_low_reg, s1_low_next, s2_low_reg;
    logic [31:0]        s2_base_reg, s2_base_next;
    logic [31:0]        s2_blk_reg, s2_blk_next;
    twla_pkg::result_t  s3_result_reg, s3_result_next;

    logic        accept;
    logic [2:0]  tile_log2;
    logic [5:0]  tile_mask;
    logic        cfg_bad;
    logic        coord_out;
    logic [17:0] n_end;
    logic [15:0] nl;
    logic [15:0] kk;
    logic [16:0] kseg_rem;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_mode_reg <= twla_pkg::MODE_HALF;
            k_total_reg   <= 17'd32;
            n_total_reg   <= 17'd64;
            n_first_reg   <= 16'd0;
            n_count_reg   <= 17'd64;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                twla_pkg::CFG_PACK_MODE: pack_mode_reg <= cfg_data[1:0];
                twla_pkg::CFG_K_TOTAL:   k_total_reg   <= cfg_data;
                twla_pkg::CFG_N_TOTAL:   n_total_reg   <= cfg_data;
                twla_pkg::CFG_N_FIRST:   n_first_reg   <= cfg_data[15:0];
                twla_pkg::CFG_N_COUNT:   n_count_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (pack_mode_reg)
            twla_pkg::MODE_HALF: tile_log2 = 3'd4;
            twla_pkg::MODE_INT8: tile_log2 = 3'd5;
            default:             tile_log2 = 3'd6;
        endcase
        tile_mask = 6'((7'd1 << tile_log2) - 7'd1);
        n_end     = {2'b00, n_first_reg} + {1'b0, n_count_reg};

        cfg_bad = (pack_mode_reg != twla_pkg::MODE_HALF &&
                   pack_mode_reg != twla_pkg::MODE_INT8 &&
                   pack_mode_reg != twla_pkg::MODE_INT4)
               || k_total_reg == 17'd0 || k_total_reg[4:0] != 5'd0
               || n_total_reg == 17'd0
               || 32'(k_total_reg) > 32'(twla_pkg::MAX_DIM)
               || 32'(n_total_reg) > 32'(twla_pkg::MAX_DIM)
               || (n_first_reg[5:0] & tile_mask) != 6'd0
               || (n_count_reg[5:0] & tile_mask) != 6'd0
               || n_end > {1'b0, n_total_reg};

        coord_out = {1'b0, request.k_index} >= k_total_reg
                 || request.n_index < n_first_reg
                 || {2'b00, request.n_index} >= n_end;

        if (cfg_bad)
        begin
            s1_status_next = twla_pkg::STATUS_MISALIGNED;
        end
        else if (coord_out)
        begin
            s1_status_next = twla_pkg::STATUS_OUTSIDE;
        end
        else
        begin
            s1_status_next = twla_pkg::STATUS_OK;
        end

        nl = request.n_index - n_first_reg;
        s1_nl_hi_next = nl & ~{10'd0, tile_mask};

        if (pack_mode_reg == twla_pkg::MODE_INT4)
        begin
            s1_kb_next   = 16'd0;
            s1_kseg_next = k_total_reg;
            kseg_rem     = 17'd0;
        end
        else
        begin
            s1_kb_next = request.k_index
                       & ~16'(twla_pkg::SEGMENT_LEN - 1);
            kseg_rem   = k_total_reg - {1'b0, s1_kb_next};
            if (32'(kseg_rem) > 32'(twla_pkg::SEGMENT_LEN))
            begin
                s1_kseg_next = 17'(twla_pkg::SEGMENT_LEN);
            end
            else
            begin
                s1_kseg_next = kseg_rem;
            end
        end

        kk = request.k_index - s1_kb_next;
        s1_low_next = (32'(kk >> 5) << (4'd5 + {1'b0, tile_log2}))
                    + (32'(nl & {10'd0, tile_mask}) << 5)
                    + 32'(kk[4:0]);
    end

    always_comb
    begin
        s2_base_next = 32'(n_count_reg) * 32'(s1_kb_reg);
        s2_blk_next  = 32'(s1_nl_hi_reg) * 32'(s1_kseg_reg);
    end

    always_comb
    begin
        s3_result_next.status = s2_status_reg;
        if (s2_status_reg == twla_pkg::STATUS_OK)
        begin
            s3_result_next.dest_offset = s2_base_reg + s2_blk_reg + s2_low_reg;
            s3_result_next.value_out   = s2_value_reg;
        end
        else
        begin
            s3_result_next.dest_offset = 32'd0;
            s3_result_next.value_out   = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_status_reg <= s1_status_next;
        s1_value_reg  <= request.element_value;
        s1_nl_hi_reg  <= s1_nl_hi_next;
        s1_kseg_reg   <= s1_kseg_next;
        s1_kb_reg     <= s1_kb_next;
        s1_low_reg    <= s1_low_next;
        s2_status_reg <= s1_status_reg;
        s2_value_reg  <= s1_value_reg;
        s2_low_reg    <= s1_low_reg;
        s2_base_reg   <= s2_base_next;
        s2_blk_reg    <= s2_blk_next;
        s3_result_reg <= s3_result_next;
    end

    assign done   = s3_valid_reg;
    assign result = s3_result_reg;

    // Every request produces exactly one result, registered through stages s1, s2 and s3.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("request did not produce a result after three cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result strobe without a matching request");

    // Error results carry no offset and no element bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != twla_pkg::STATUS_OK) |->
            (result.dest_offset == 32'd0 && result.value_out == 16'd0))
        else $error("error result carries a non-zero payload");

endmodule
